// File: rtl/lsom_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lsom_pkg;

  localparam int LAYERS_DEF = 256;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_SIZE    = 3'd1;
  localparam logic [2:0] OP_HEIGHT  = 3'd2;
  localparam logic [2:0] OP_SLIDE   = 3'd3;
  localparam logic [2:0] OP_FREE    = 3'd4;
  localparam logic [2:0] OP_REFRESH = 3'd5;

  typedef enum logic [1:0] {
    SEL_STATUS,
    SEL_AREA_OLD,
    SEL_AREA_NEW,
    SEL_REFRESH
  } sel_t;

  typedef enum logic [1:0] {
    MD_DOWN_VIS,
    MD_HIDE,
    MD_UP_VIS,
    MD_SHOW
  } mode_t;

  typedef struct packed {
    logic latch;
    logic rd;
    logic hgt_wr;
    logic loop_init;
    logic mv_rd;
    logic mv_wr;
    logic loop_fin;
    logic pos_wr;
    logic size_wr;
    logic use_set;
    logic use_clr;
    logic cnt_clr;
    logic cnt_inc;
    logic alloc_fail;
    logic load;
    logic last;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       valid_id;
    logic       vis;
    logic       changed;
    logic       more;
    logic       cnt_free;
    logic       cnt_end;
    logic       out_full;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/lsom_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lsom_ctrl
  import lsom_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_ALLOC   = 12'b000000000010,
    S_RD      = 12'b000000000100,
    S_DEC     = 12'b000000001000,
    S_MV_RD   = 12'b000000010000,
    S_MV_WR   = 12'b000000100000,
    S_MV_END  = 12'b000001000000,
    S_EM_AREA = 12'b000010000000,
    S_EM_OLD  = 12'b000100000000,
    S_EM_NEW  = 12'b001000000000,
    S_EM_REF  = 12'b010000000000,
    S_ST      = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.sel = SEL_STATUS;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_nxt = (sts.op == OP_ALLOC) ? S_ALLOC : S_DEC;
      end
      S_ALLOC: begin
        if (sts.cnt_free) begin
          cmd.use_set = 1'b1;
          state_nxt = S_ST;
        end else if (sts.cnt_end) begin
          cmd.alloc_fail = 1'b1;
          state_nxt = S_ST;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_DEC: begin
        state_nxt = S_ST;
        if (sts.valid_id) begin
          case (sts.op)
            OP_SIZE: cmd.size_wr = 1'b1;
            OP_HEIGHT: begin
              if (sts.changed) begin
                cmd.hgt_wr = 1'b1;
                cmd.loop_init = 1'b1;
                state_nxt = S_MV_RD;
              end
            end
            OP_FREE: begin
              cmd.use_clr = 1'b1;
              if (sts.vis) begin
                cmd.hgt_wr = 1'b1;
                cmd.loop_init = 1'b1;
                state_nxt = S_MV_RD;
              end
            end
            OP_SLIDE: begin
              if (sts.vis) begin
                state_nxt = S_EM_OLD;
              end else begin
                cmd.pos_wr = 1'b1;
              end
            end
            OP_REFRESH: begin
              if (sts.vis) state_nxt = S_EM_REF;
            end
            default: state_nxt = S_ST;
          endcase
        end
      end
      S_MV_RD: begin
        if (sts.more) begin
          cmd.mv_rd = 1'b1;
          state_nxt = S_MV_WR;
        end else begin
          state_nxt = S_MV_END;
        end
      end
      S_MV_WR: begin
        cmd.mv_wr = 1'b1;
        state_nxt = S_MV_RD;
      end
      S_MV_END: begin
        cmd.loop_fin = 1'b1;
        state_nxt = S_EM_AREA;
      end
      S_EM_AREA: begin
        if (!sts.out_full) begin
          cmd.load = 1'b1;
          cmd.last = 1'b1;
          cmd.sel = SEL_AREA_OLD;
          state_nxt = S_IDLE;
        end
      end
      S_EM_OLD: begin
        if (!sts.out_full) begin
          cmd.load = 1'b1;
          cmd.sel = SEL_AREA_OLD;
          cmd.pos_wr = 1'b1;
          state_nxt = S_EM_NEW;
        end
      end
      S_EM_NEW: begin
        if (!sts.out_full) begin
          cmd.load = 1'b1;
          cmd.last = 1'b1;
          cmd.sel = SEL_AREA_NEW;
          state_nxt = S_IDLE;
        end
      end
      S_EM_REF: begin
        if (!sts.out_full) begin
          cmd.load = 1'b1;
          cmd.last = 1'b1;
          cmd.sel = SEL_REFRESH;
          state_nxt = S_IDLE;
        end
      end
      S_ST: begin
        if (!sts.out_full) begin
          cmd.load = 1'b1;
          cmd.last = 1'b1;
          cmd.sel = SEL_STATUS;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // a move write always follows its read
  a_mv_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mv_wr |-> $past(cmd.mv_rd))
    else $error("move write without read");

  // a new item is only taken with no shift in flight
  a_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |-> !cmd.mv_rd && !cmd.mv_wr && !cmd.load)
    else $error("input taken while busy");

  // results are only loaded from emit or status states
  a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_EM_AREA) || (state_r == S_EM_OLD) ||
                 (state_r == S_EM_NEW) || (state_r == S_EM_REF) || (state_r == S_ST))
    else $error("load outside emit state");

endmodule
`default_nettype wire

// File: rtl/lsom_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module lsom_dpath
  import lsom_pkg::*;
#(
  parameter int LAYERS = LAYERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [2:0]         in_opcode,
  input  wire logic [7:0]         in_layer,
  input  wire logic signed [8:0]  in_req_height,
  input  wire logic signed [11:0] in_pos_x,
  input  wire logic signed [11:0] in_pos_y,
  input  wire logic [10:0]        in_end_x,
  input  wire logic [10:0]        in_end_y,
  input  wire logic [10:0]        in_size_w,
  input  wire logic [10:0]        in_size_h,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_kind,
  output logic                    out_ok,
  output logic [7:0]              out_granted_layer,
  output logic signed [12:0]      out_rect_x0,
  output logic signed [12:0]      out_rect_y0,
  output logic signed [12:0]      out_rect_x1,
  output logic signed [12:0]      out_rect_y1,
  output logic                    out_last
);

  localparam int IW = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  function automatic logic [IW-1:0] wrap(input logic signed [10:0] v);
    logic signed [11:0] t;
    t = {v[10], v};
    if (t < 0) begin
      t = t + 12'(LAYERS);
    end else if (t >= 12'(LAYERS)) begin
      t = t - 12'(LAYERS);
    end
    return t[IW-1:0];
  endfunction

  function automatic logic signed [12:0] sat(input logic signed [13:0] v);
    logic signed [12:0] r;
    if (v < -14'sd2048) begin
      r = -13'sd2048;
    end else if (v > 14'sd4095) begin
      r = 13'sd4095;
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

  // latched item
  logic [2:0]         op_r;
  logic [7:0]         id_r;
  logic signed [8:0]  req_r;
  logic signed [11:0] px_r, py_r;
  logic [10:0]        ex_r, ey_r, sw_r, sh_r;

  // layer stores
  logic signed [9:0]  hgt_mem [LAYERS];
  logic signed [11:0] pxm [LAYERS];
  logic signed [11:0] pym [LAYERS];
  logic [10:0]        wm [LAYERS];
  logic [10:0]        hm [LAYERS];
  logic [IW-1:0]      ord_mem [LAYERS];

  logic signed [9:0]  hgt_q;
  logic signed [11:0] px_q, py_q;
  logic [10:0]        w_q, h_q;
  logic [IW-1:0]      ord_q;

  logic [LAYERS-1:0]  use_r;
  logic signed [9:0]  top_r;
  logic signed [10:0] i_r, lim_r;
  logic               down_r;
  mode_t              mode_r;
  logic [IW-1:0]      cnt_r;
  logic               ok_r;
  logic [7:0]         grant_r;
  logic               out_valid_r;

  logic [IW-1:0]      id_idx;
  logic signed [10:0] top1, reqx, h, old;
  logic signed [10:0] src, step;
  mode_t              mode;
  logic               hgt_we, ord_we;
  logic [IW-1:0]      hgt_wa, ord_wa;
  logic signed [9:0]  hgt_wd;
  logic [IW-1:0]      ord_wd;
  logic signed [13:0] ax0, ay0, ax1, ay1;

  assign id_idx = id_r[IW-1:0];
  assign top1 = {top_r[9], top_r} + 11'sd1;
  assign reqx = (op_r == OP_FREE) ? -11'sd1 : {{2{req_r[8]}}, req_r};
  assign old = {hgt_q[9], hgt_q};
  assign step = down_r ? -11'sd1 : 11'sd1;
  assign src = i_r + step;

  always_comb begin
    h = (reqx > top1) ? top1 : reqx;
    if (h < -11'sd1) h = -11'sd1;
    if (old > h) begin
      mode = (h >= 0) ? MD_DOWN_VIS : MD_HIDE;
    end else begin
      mode = (old >= 0) ? MD_UP_VIS : MD_SHOW;
    end
  end

  always_comb begin
    sts.op = op_r;
    sts.valid_id = (32'(id_r) < LAYERS) && use_r[id_idx];
    sts.vis = !hgt_q[9];
    sts.changed = (old != h);
    sts.more = down_r ? (i_r > lim_r) : (i_r < lim_r);
    sts.cnt_free = !use_r[cnt_r];
    sts.cnt_end = (cnt_r == IW'(LAYERS - 1));
    sts.out_full = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_opcode;
      id_r <= in_layer;
      req_r <= in_req_height;
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      ex_r <= in_end_x;
      ey_r <= in_end_y;
      sw_r <= in_size_w;
      sh_r <= in_size_h;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      px_q <= pxm[id_idx];
      py_q <= pym[id_idx];
      w_q <= wm[id_idx];
      h_q <= hm[id_idx];
    end
    if (cmd.pos_wr) begin
      pxm[id_idx] <= px_r;
      pym[id_idx] <= py_r;
    end
    if (cmd.size_wr) begin
      wm[id_idx] <= sw_r;
      hm[id_idx] <= sh_r;
    end
  end

  always_comb begin
    hgt_we = 1'b1;
    hgt_wa = cnt_r;
    hgt_wd = -10'sd1;
    if (cmd.use_set) begin
      hgt_wa = cnt_r;
      hgt_wd = -10'sd1;
    end else if (cmd.hgt_wr) begin
      hgt_wa = id_idx;
      hgt_wd = h[9:0];
    end else if (cmd.mv_wr) begin
      hgt_wa = ord_q;
      hgt_wd = i_r[9:0];
    end else begin
      hgt_we = 1'b0;
    end
    ord_we = 1'b1;
    ord_wa = wrap(i_r);
    ord_wd = ord_q;
    if (cmd.mv_wr) begin
      ord_wa = wrap(i_r);
      ord_wd = ord_q;
    end else if (cmd.loop_fin && mode_r != MD_HIDE) begin
      ord_wa = wrap(h);
      ord_wd = id_idx;
    end else begin
      ord_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) hgt_q <= hgt_mem[id_idx];
    if (hgt_we) hgt_mem[hgt_wa] <= hgt_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.mv_rd) ord_q <= ord_mem[wrap(src)];
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
  end

  // shift cursor
  always_ff @(posedge clk) begin
    if (cmd.loop_init) begin
      mode_r <= mode;
      case (mode)
        MD_DOWN_VIS: begin
          i_r <= old;
          lim_r <= h;
          down_r <= 1'b1;
        end
        MD_HIDE: begin
          i_r <= old;
          lim_r <= {top_r[9], top_r};
          down_r <= 1'b0;
        end
        MD_UP_VIS: begin
          i_r <= old;
          lim_r <= h;
          down_r <= 1'b0;
        end
        default: begin
          i_r <= top1;
          lim_r <= h;
          down_r <= 1'b1;
        end
      endcase
    end else if (cmd.mv_wr) begin
      i_r <= src;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= '0;
      top_r <= -10'sd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.use_set) use_r[cnt_r] <= 1'b1;
      if (cmd.use_clr) use_r[id_idx] <= 1'b0;
      if (cmd.loop_fin) begin
        if (mode_r == MD_HIDE) top_r <= top_r - 10'sd1;
        if (mode_r == MD_SHOW) top_r <= top_r + 10'sd1;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.latch) begin
      ok_r <= 1'b1;
      grant_r <= '0;
    end else if (cmd.use_set) begin
      grant_r <= 8'(cnt_r);
    end else if (cmd.alloc_fail) begin
      ok_r <= 1'b0;
    end
  end

  always_comb begin
    ax0 = 14'(px_q);
    ay0 = 14'(py_q);
    if (cmd.sel == SEL_AREA_NEW) begin
      ax0 = 14'(px_r);
      ay0 = 14'(py_r);
    end
    ax1 = ax0 + 14'(w_q);
    ay1 = ay0 + 14'(h_q);
    if (cmd.sel == SEL_REFRESH) begin
      ax0 = 14'(px_q) + 14'(px_r);
      ay0 = 14'(py_q) + 14'(py_r);
      ax1 = 14'(px_q) + 14'(ex_r);
      ay1 = 14'(py_q) + 14'(ey_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_last <= cmd.last;
      if (cmd.sel == SEL_STATUS) begin
        out_kind <= 1'b0;
        out_ok <= ok_r;
        out_granted_layer <= grant_r;
        out_rect_x0 <= '0;
        out_rect_y0 <= '0;
        out_rect_x1 <= '0;
        out_rect_y1 <= '0;
      end else begin
        out_kind <= 1'b1;
        out_ok <= 1'b1;
        out_granted_layer <= '0;
        out_rect_x0 <= sat(ax0);
        out_rect_y0 <= sat(ay0);
        out_rect_x1 <= sat(ax1);
        out_rect_y1 <= sat(ay1);
      end
    end
  end

  assign out_valid = out_valid_r;

  // never overwrite a result that was not transferred
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !out_valid_r)
    else $error("result overwritten");

  // allocation only claims a free layer
  a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.use_set |-> !use_r[cnt_r])
    else $error("claimed a layer in use");

  // the scan never runs past the last layer
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> cnt_r != IW'(LAYERS - 1))
    else $error("scan past end");

endmodule
`default_nettype wire

// File: rtl/layer_stack_order_manager_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Layer stack manager: keeps up to LAYERS screen layers, their position, size and
// stacking height, and answers each operation with one status result or one or two
// dirty rectangles (last marks the final one). Items are handled one at a time. An
// allocate scans the in-use marks one layer a cycle; a height change or a free of a
// visible layer shifts the order table with one read and one write of the table
// memory per moved entry. A waiting result does not block the next item from being
// taken.
module layer_stack_order_manager_top
  import lsom_pkg::*;
#(
  parameter int LAYERS = LAYERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_opcode,
  input  wire logic [7:0]         in_layer,
  input  wire logic signed [8:0]  in_req_height,
  input  wire logic signed [11:0] in_pos_x,
  input  wire logic signed [11:0] in_pos_y,
  input  wire logic [10:0]        in_end_x,
  input  wire logic [10:0]        in_end_y,
  input  wire logic [10:0]        in_size_w,
  input  wire logic [10:0]        in_size_h,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_kind,
  output logic                    out_ok,
  output logic [7:0]              out_granted_layer,
  output logic signed [12:0]      out_rect_x0,
  output logic signed [12:0]      out_rect_y0,
  output logic signed [12:0]      out_rect_x1,
  output logic signed [12:0]      out_rect_y1,
  output logic                    out_last
);

  cmd_t cmd;
  sts_t sts;

  lsom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsom_dpath #(
    .LAYERS (LAYERS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_opcode),
    .in_layer          (in_layer),
    .in_req_height     (in_req_height),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_size_w         (in_size_w),
    .in_size_h         (in_size_h),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_ok            (out_ok),
    .out_granted_layer (out_granted_layer),
    .out_rect_x0       (out_rect_x0),
    .out_rect_y0       (out_rect_y0),
    .out_rect_x1       (out_rect_x1),
    .out_rect_y1       (out_rect_y1),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire

// File: verif/tb_layer_stack_order_manager_top.sv
`timescale 1ns / 1ps
module tb_layer_stack_order_manager_top;
  import lsom_pkg::*;

  localparam int NLAYERS = 256;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         layer;
    logic signed [8:0]  req_height;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [10:0]        end_x;
    logic [10:0]        end_y;
    logic [10:0]        size_w;
    logic [10:0]        size_h;
  } op_item_t;

  typedef struct packed {
    logic               kind;
    logic               ok;
    logic [7:0]         granted_layer;
    logic signed [12:0] x0;
    logic signed [12:0] y0;
    logic signed [12:0] x1;
    logic signed [12:0] y1;
    logic               last;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_opcode = '0;
  logic [7:0] in_layer = '0;
  logic signed [8:0] in_req_height = '0;
  logic signed [11:0] in_pos_x = '0;
  logic signed [11:0] in_pos_y = '0;
  logic [10:0] in_end_x = '0;
  logic [10:0] in_end_y = '0;
  logic [10:0] in_size_w = '0;
  logic [10:0] in_size_h = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic out_ok;
  logic [7:0] out_granted_layer;
  logic signed [12:0] out_rect_x0;
  logic signed [12:0] out_rect_y0;
  logic signed [12:0] out_rect_x1;
  logic signed [12:0] out_rect_y1;
  logic out_last;

  layer_stack_order_manager_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // layer state mirror
  bit            used [NLAYERS];
  bit            sized [NLAYERS];
  bit            placed [NLAYERS];
  int            hgt [NLAYERS];
  int            lx [NLAYERS];
  int            ly [NLAYERS];
  int            lw [NLAYERS];
  int            lh [NLAYERS];
  int            order [NLAYERS];
  int            top_idx;

  op_item_t pending_ops[$];
  answer_t  expected_answers[$];

  int  mismatches = 0;
  int  unexpected = 0;
  int  accepted_ops = 0;
  int  answers_seen = 0;
  int  rects_seen = 0;
  int  idle_cycles = 0;
  bit  timed_out = 1'b0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  function automatic logic signed [12:0] clip_edge(int v);
    if (v < -2048) v = -2048;
    if (v > 4095) v = 4095;
    return v[12:0];
  endfunction

  function automatic answer_t status_answer(bit ok, int granted);
    answer_t a;
    a = '0;
    a.ok = ok;
    a.granted_layer = granted[7:0];
    return a;
  endfunction

  function automatic answer_t rect_answer(int x0, int y0, int x1, int y1);
    answer_t a;
    a = '0;
    a.kind = 1'b1;
    a.ok = 1'b1;
    a.x0 = clip_edge(x0);
    a.y0 = clip_edge(y0);
    a.x1 = clip_edge(x1);
    a.y1 = clip_edge(y1);
    return a;
  endfunction

  function automatic answer_t area_of(int id);
    return rect_answer(lx[id], ly[id], lx[id] + lw[id], ly[id] + lh[id]);
  endfunction

  function automatic void shift_entry(int dst, int src);
    int id;
    id = order[src];
    order[dst] = id;
    hgt[id] = dst;
  endfunction

  function automatic bit restack(int id, int h);
    int old;
    old = hgt[id];
    if (h > top_idx + 1) h = top_idx + 1;
    if (h < -1) h = -1;
    hgt[id] = h;
    if (old > h) begin
      if (h >= 0) begin
        for (int i = old; i > h; i--) shift_entry(i, i - 1);
        order[h] = id;
      end else begin
        for (int i = old; i < top_idx; i++) shift_entry(i, i + 1);
        top_idx--;
      end
      return 1'b1;
    end
    if (old < h) begin
      if (old >= 0) begin
        for (int i = old; i < h; i++) shift_entry(i, i + 1);
      end else begin
        for (int i = top_idx; i >= h; i--) shift_entry(i + 1, i);
        top_idx++;
      end
      order[h] = id;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_answers(op_item_t it);
    answer_t res[$];
    int id;
    id = it.layer;
    if (it.opcode == OP_ALLOC) begin
      for (int i = 0; i < NLAYERS; i++) begin
        if (!used[i]) begin
          used[i] = 1'b1;
          hgt[i] = -1;
          res.push_back(status_answer(1'b1, i));
          break;
        end
      end
      if (res.size() == 0) res.push_back(status_answer(1'b0, 0));
    end else if (it.opcode <= OP_REFRESH && used[id]) begin
      case (it.opcode)
        OP_SIZE: begin
          lw[id] = it.size_w;
          lh[id] = it.size_h;
          sized[id] = 1'b1;
        end
        OP_HEIGHT: if (restack(id, int'(it.req_height))) res.push_back(area_of(id));
        OP_SLIDE: begin
          if (hgt[id] >= 0) res.push_back(area_of(id));
          lx[id] = it.pos_x;
          ly[id] = it.pos_y;
          placed[id] = 1'b1;
          if (hgt[id] >= 0) res.push_back(area_of(id));
        end
        OP_FREE: begin
          if (hgt[id] >= 0 && restack(id, -1)) res.push_back(area_of(id));
          used[id] = 1'b0;
        end
        default: if (hgt[id] >= 0) begin
          res.push_back(rect_answer(lx[id] + it.pos_x, ly[id] + it.pos_y,
                                    lx[id] + it.end_x, ly[id] + it.end_y));
        end
      endcase
    end
    if (res.size() == 0) res.push_back(status_answer(1'b1, 0));
    res[res.size() - 1].last = 1'b1;
    foreach (res[k]) expected_answers.push_back(res[k]);
  endfunction

  // planning mirror so that generated items never touch unwritten position or size
  bit p_used [NLAYERS];
  bit p_ready [NLAYERS];

  function automatic op_item_t rand_fields();
    op_item_t it;
    it.opcode = '0;
    it.layer = 8'($urandom);
    it.req_height = 9'($urandom);
    it.pos_x = 12'($urandom);
    it.pos_y = 12'($urandom);
    it.end_x = 11'($urandom);
    it.end_y = 11'($urandom);
    it.size_w = 11'($urandom);
    it.size_h = 11'($urandom);
    return it;
  endfunction

  function automatic int plan_alloc();
    for (int i = 0; i < NLAYERS; i++) if (!p_used[i]) begin
      p_used[i] = 1'b1;
      return i;
    end
    return -1;
  endfunction

  task automatic queue_op(op_item_t it);
    if (it.opcode == OP_FREE && p_used[it.layer]) begin
      p_used[it.layer] = 1'b0;
      p_ready[it.layer] = 1'b0;
    end
    pending_ops.push_back(it);
  endtask

  // allocate, size and place a layer so it can be shown safely
  task automatic queue_setup(int small_size);
    op_item_t it;
    int id;
    id = plan_alloc();
    it = rand_fields();
    it.opcode = OP_ALLOC;
    queue_op(it);
    if (id < 0) return;
    it = rand_fields();
    it.opcode = OP_SIZE;
    it.layer = id[7:0];
    if (small_size) begin
      it.size_w = 11'($urandom_range(0, 300));
      it.size_h = 11'($urandom_range(0, 300));
    end
    queue_op(it);
    it = rand_fields();
    it.opcode = OP_SLIDE;
    it.layer = id[7:0];
    queue_op(it);
    p_ready[id] = 1'b1;
  endtask

  function automatic int pick_ready();
    int c;
    for (int t = 0; t < 8; t++) begin
      c = $urandom_range(0, 31);
      if (p_ready[c]) return c;
    end
    for (int i = 0; i < NLAYERS; i++) if (p_ready[i]) return i;
    return -1;
  endfunction

  task automatic queue_random_op();
    op_item_t it;
    int id;
    int r;
    r = $urandom_range(0, 99);
    it = rand_fields();
    id = pick_ready();
    if (r < 8 || id < 0) begin
      queue_setup(1);
    end else if (r < 14) begin
      // noise: unknown opcode or layer not in use
      it.opcode = $urandom_range(0, 1) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(1, 5));
      while (p_used[it.layer]) it.layer = 8'($urandom);
      queue_op(it);
    end else begin
      it.layer = id[7:0];
      it.opcode = 3'($urandom_range(1, 5));
      if (it.opcode == OP_HEIGHT && $urandom_range(0, 1))
        it.req_height = 9'(int'($urandom_range(0, 12)) - 1);
      if (it.opcode == OP_FREE && $urandom_range(0, 2) != 0) it.opcode = OP_HEIGHT;
      if (it.opcode == OP_SIZE && $urandom_range(0, 3) != 0) begin
        it.size_w = 11'($urandom_range(0, 400));
        it.size_h = 11'($urandom_range(0, 400));
      end
      queue_op(it);
    end
  endtask

  initial begin
    op_item_t it;
    int id;
    for (int i = 0; i < NLAYERS; i++) begin
      used[i] = 0; sized[i] = 0; placed[i] = 0;
      hgt[i] = 0; lx[i] = 0; ly[i] = 0; lw[i] = 0; lh[i] = 0; order[i] = 0;
      p_used[i] = 0; p_ready[i] = 0;
    end
    top_idx = -1;

    // directed part: extremes and special cases
    it = rand_fields(); it.opcode = 3'd7; queue_op(it);
    it = rand_fields(); it.opcode = OP_SLIDE; it.layer = 8'd255; queue_op(it);
    queue_setup(0);
    it = rand_fields(); it.opcode = OP_SIZE; it.layer = 0;
    it.size_w = 11'h7ff; it.size_h = 11'h7ff; queue_op(it);
    it = rand_fields(); it.opcode = OP_REFRESH; it.layer = 0; queue_op(it);
    it = rand_fields(); it.opcode = OP_SLIDE; it.layer = 0;
    it.pos_x = 12'sh7ff; it.pos_y = 12'sh7ff; queue_op(it);
    it = rand_fields(); it.opcode = OP_HEIGHT; it.layer = 0;
    it.req_height = 9'sd255; queue_op(it);
    it.req_height = 9'sd0; queue_op(it);
    it = rand_fields(); it.opcode = OP_SLIDE; it.layer = 0;
    it.pos_x = -12'sd2048; it.pos_y = -12'sd2048; queue_op(it);
    it = rand_fields(); it.opcode = OP_REFRESH; it.layer = 0;
    it.pos_x = 12'sd100; it.end_x = 11'd0; it.end_y = 11'h7ff; queue_op(it);
    queue_setup(0);
    it = rand_fields(); it.opcode = OP_HEIGHT; it.layer = 1;
    it.req_height = 9'sd0; queue_op(it);
    it.req_height = -9'sd1; queue_op(it);
    it.req_height = -9'sd1; queue_op(it);
    it = rand_fields(); it.opcode = OP_REFRESH; it.layer = 1; queue_op(it);
    it = rand_fields(); it.opcode = OP_FREE; it.layer = 0; queue_op(it);
    it = rand_fields(); it.opcode = OP_FREE; it.layer = 1; queue_op(it);

    // fill the pool to hit the no-free-layer answer, then bring several up
    for (int i = 0; i < NLAYERS + 1; i++) begin
      it = rand_fields(); it.opcode = OP_ALLOC;
      id = plan_alloc();
      queue_op(it);
    end
    for (int i = 0; i < 40; i++) begin
      it = rand_fields(); it.opcode = OP_FREE; it.layer = 8'(i); queue_op(it);
    end
    for (int i = 0; i < 130; i++) queue_random_op();
    // shows deep in a tall stack
    for (int i = 0; i < 30; i++) begin
      id = pick_ready();
      it = rand_fields(); it.opcode = OP_HEIGHT; it.layer = id[7:0];
      it.req_height = $urandom_range(0, 1) ? 9'sd0 : 9'sd255;
      if (id >= 0) queue_op(it);
    end
  end

  // driver
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_answers({in_opcode, in_layer, in_req_height, in_pos_x, in_pos_y,
                         in_end_x, in_end_y, in_size_w, in_size_h});
        accepted_ops++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(1, 17) - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op_item_t nx;
          nx = pending_ops.pop_front();
          in_valid <= 1'b1;
          {in_opcode, in_layer, in_req_height, in_pos_x, in_pos_y,
           in_end_x, in_end_y, in_size_w, in_size_h} <= nx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up
  int hold_count = 0;
  always @(posedge clk) begin
    if (accepted_ops == 60 && hold_count == 0) hold_count <= 3000;
    else if (hold_count > 1) hold_count <= hold_count - 1;
    hold_req <= hold_count > 1;
  end

  // monitor
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        answer_t got, exp_a;
        got = {out_kind, out_ok, out_granted_layer, out_rect_x0, out_rect_y0,
               out_rect_x1, out_rect_y1, out_last};
        answers_seen++;
        if (out_kind) rects_seen++;
        if (expected_answers.size() == 0) begin
          unexpected++;
          if (unexpected + mismatches <= 10) $display("unexpected transfer %p", got);
        end else begin
          exp_a = expected_answers.pop_front();
          if (got !== exp_a) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
              $display("mismatch: expected %p, got %p", exp_a, got);
          end
        end
      end
      if (hold_req) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        timed_out <= 1'b1;
        $display("layer_stack_order_manager_top test failed");
        $finish;
      end
    end
  end

  initial begin
    int tail;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() > 0);
    while (pending_ops.size() > 150) @(posedge clk);
    calm = 1'b1;
    while (pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    tail = 0;
    while (tail < 600) begin
      @(posedge clk);
      tail++;
    end
    $display("ran %0d operations, checked %0d results (%0d dirty rectangles)",
             accepted_ops, answers_seen, rects_seen);
    if (mismatches == 0 && unexpected == 0 && expected_answers.size() == 0) begin
      $display("layer_stack_order_manager_top test passed");
    end else begin
      $display("%0d mismatches, %0d unexpected", mismatches, unexpected);
      $display("layer_stack_order_manager_top test failed");
    end
    $finish;
  end

endmodule

// File: layer_stack_order_manager_top.f
rtl/lsom_pkg.sv
rtl/lsom_ctrl.sv
rtl/lsom_dpath.sv
rtl/layer_stack_order_manager_top.sv
verif/tb_layer_stack_order_manager_top.sv
